FILE: rtl/sspc_pkg.sv
// Shared types, codes and constants of the servo slew position controller.
`default_nettype none

package sspc_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_COMMAND = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;

  // Command kinds.
  localparam logic [7:0] KIND_POSITION = 8'd0;
  localparam logic [7:0] KIND_SPEED    = 8'd1;

  // Servo mode codes as seen on the result channel.
  localparam logic [2:0] MODE_DISABLED = 3'd0;
  localparam logic [2:0] MODE_IDLE     = 3'd1;
  localparam logic [2:0] MODE_MOVING   = 3'd2;
  localparam logic [2:0] MODE_HOLDING  = 3'd3;
  localparam logic [2:0] MODE_FAULT    = 3'd4;

  localparam logic [7:0] BROADCAST_ID = 8'hFF;

  // Divider geometry: a 16x16 product over a divisor of up to 17 bits.
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 17;
  localparam int unsigned DIV_STEPS  = DIVIDEND_W / 2;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // Speed is in degrees per second, time in microseconds, angle in tenths.
  localparam logic [DIVISOR_W-1:0] SLEW_DIVISOR = 17'd100000;

  // Reset values.
  localparam logic [7:0]         RST_NODE_ID    = 8'd0;
  localparam logic signed [11:0] RST_ANGLE_MIN  = -12'sd900;
  localparam logic signed [11:0] RST_ANGLE_MAX  = 12'sd900;
  localparam logic signed [11:0] RST_ANGLE_TRIM = 12'sd0;
  localparam logic [15:0]        RST_PULSE_MIN  = 16'd1000;
  localparam logic [15:0]        RST_PULSE_MAX  = 16'd2000;
  localparam logic [15:0]        RST_FRAME      = 16'd20000;
  localparam logic [15:0]        RST_SPEED      = 16'd180;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_NODE_ID     = 3'd0,
    CFG_ANGLE_MIN   = 3'd1,
    CFG_ANGLE_MAX   = 3'd2,
    CFG_ANGLE_TRIM  = 3'd3,
    CFG_PULSE_MIN   = 3'd4,
    CFG_PULSE_MAX   = 3'd5,
    CFG_FRAME       = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        elapsed_us;
    logic [7:0]         dest_id;
    logic [7:0]         command_kind;
    logic signed [15:0] target_value;
    logic [15:0]        speed_value;
    logic               enable_flag;
    logic               torque_flag;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         servo_mode;
    logic signed [15:0] present_angle;
    logic signed [15:0] goal_angle;
    logic [15:0]        pulse_width_us;
    logic [15:0]        pulse_period_us;
    logic               torque_on;
    logic [15:0]        speed_now;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  reg_index;
    logic [15:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sspc_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
`default_nettype none

interface sspc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/servo_slew_position_controller_top.sv
// Top level of the RC servo controller with slew-rate limited motion.
`default_nettype none

// Servo position controller. Each input item is a tick, a servo command or
// a start, and each gives exactly one result item holding the servo state.
// A tick moves the present angle toward the goal by at most
// speed * elapsed_us / 100000 tenths of a degree (at least one), and any
// pulse refresh maps the clamped, trimmed angle linearly onto the pulse
// limits. Both divisions share one divider that retires two quotient bits
// per cycle, and one 16x16 multiplier feeds it. No pulse is computed for
// an unused code, a foreign address, a disable or a tick without motion;
// a start or an enabling command runs the pulse mapping, and a tick that
// moves the angle runs the slew division before it. A zero angle span
// skips the pulse division. A new item is taken once the previous result
// sits in the output register; the result waits there until the sink
// takes it.
module servo_slew_position_controller_top (
  input  logic          clk,
  input  logic          rst_n,
  sspc_stream_if.sink   in_if,
  sspc_stream_if.source out_if,
  sspc_stream_if.sink   cfg_if
);
  import sspc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_LIM_MUL = 8'b0000_0010,
    S_LIM_DIV = 8'b0000_0100,
    S_STEP    = 8'b0000_1000,
    S_PM_PREP = 8'b0001_0000,
    S_PM_MUL  = 8'b0010_0000,
    S_PM_DIV  = 8'b0100_0000,
    S_PM_FIN  = 8'b1000_0000
  } seq_state_t;

  // Configuration registers.
  logic [7:0]         node_id_r;
  logic signed [11:0] angle_min_r, angle_max_r, angle_trim_r;
  logic [15:0]        pulse_min_r, pulse_max_r, frame_r;

  // Sequencer and servo state.
  seq_state_t         state_r, state_nxt;
  logic               done_pending_r, done_pending_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic               enabled_r, enabled_nxt;
  logic signed [11:0] cur_r, cur_nxt;
  logic signed [11:0] tgt_r, tgt_nxt;
  logic [15:0]        speed_r, speed_nxt;
  logic               torque_r, torque_nxt;
  logic [15:0]        pulse_r, pulse_nxt;

  // Per-item working registers.
  logic               acc_r, acc_nxt;
  logic [15:0]        elapsed_r, elapsed_nxt;
  logic [12:0]        mag_a_r, mag_a_nxt;
  logic [15:0]        mag_p_r, mag_p_nxt;
  logic [11:0]        mag_s_r, mag_s_nxt;
  logic               neg_r, neg_nxt;
  logic               span_zero_r, span_zero_nxt;

  // Output register.
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Shared multiplier and divider.
  logic [15:0]             mul_a, mul_b;
  logic [DIVIDEND_W-1:0]   mul_p;
  logic                    div_start;
  logic [DIVISOR_W-1:0]    div_dvs;
  logic [DIVIDEND_W-1:0]   div_quo;
  div_stat_t               div_stat;

  logic               in_fire, out_fire;
  logic signed [15:0] lo16, hi16, cur16;
  logic               dest_hit, active;

  // Slew step.
  logic [11:0]        lim12;
  logic signed [12:0] lim13, dlt13, stp13, new13;

  // Pulse mapping operands.
  logic signed [11:0] clamp_cur;
  logic signed [12:0] a13;
  logic signed [13:0] da14, da14_neg;
  logic signed [16:0] dp17, dp17_neg;
  logic signed [12:0] span13, span13_neg;

  // Pulse mapping finish.
  logic signed [30:0] qe31, sq31, p31, plo31, phi31;
  logic [15:0]        plo, phi;

  in_item_t           item;

  function automatic logic signed [11:0] clamp_angle(
    input logic signed [15:0] a,
    input logic signed [15:0] lo,
    input logic signed [15:0] hi
  );
    logic signed [15:0] t;
    t = a;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    return t[11:0];
  endfunction

  assign item     = in_if.data;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;

  assign in_if.ready  = (state_r == S_IDLE) && !done_pending_r;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  assign lo16  = {{4{angle_min_r[11]}}, angle_min_r};
  assign hi16  = {{4{angle_max_r[11]}}, angle_max_r};
  assign cur16 = {{4{cur_r[11]}}, cur_r};

  assign dest_hit = (item.dest_id == node_id_r) || (item.dest_id == BROADCAST_ID);
  assign active   = enabled_r && (mode_r != MODE_FAULT) && (mode_r != MODE_DISABLED);

  // The quotient can exceed any reachable distance, so it saturates at
  // the largest 12-bit step before the compare.
  always_comb begin
    lim12 = (|div_quo[DIVIDEND_W-1:12]) ? 12'hFFF : div_quo[11:0];
    if (lim12 == 12'd0) lim12 = 12'd1;
    lim13 = {1'b0, lim12};
    dlt13 = {tgt_r[11], tgt_r} - {cur_r[11], cur_r};
    if (dlt13 > lim13)       stp13 = lim13;
    else if (dlt13 < -lim13) stp13 = -lim13;
    else                     stp13 = dlt13;
    new13 = {cur_r[11], cur_r} + stp13;
  end

  always_comb begin
    clamp_cur  = clamp_angle(cur16, lo16, hi16);
    a13        = {clamp_cur[11], clamp_cur} + {angle_trim_r[11], angle_trim_r};
    da14       = {a13[12], a13} - {angle_min_r[11], angle_min_r[11], angle_min_r};
    da14_neg   = -da14;
    dp17       = {1'b0, pulse_max_r} - {1'b0, pulse_min_r};
    dp17_neg   = -dp17;
    span13     = {angle_max_r[11], angle_max_r} - {angle_min_r[11], angle_min_r};
    span13_neg = -span13;
  end

  // The mapped quotient stays below 2^29, so 31 signed bits hold the sum.
  always_comb begin
    plo   = (pulse_min_r < pulse_max_r) ? pulse_min_r : pulse_max_r;
    phi   = (pulse_min_r < pulse_max_r) ? pulse_max_r : pulse_min_r;
    qe31  = {2'b00, div_quo[28:0]};
    sq31  = neg_r ? -qe31 : qe31;
    p31   = {15'd0, pulse_min_r} + sq31;
    plo31 = {15'd0, plo};
    phi31 = {15'd0, phi};
    if (p31 < plo31) p31 = plo31;
    if (p31 > phi31) p31 = phi31;
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt        = state_r;
    done_pending_nxt = done_pending_r;
    mode_nxt         = mode_r;
    enabled_nxt      = enabled_r;
    cur_nxt          = cur_r;
    tgt_nxt          = tgt_r;
    speed_nxt        = speed_r;
    torque_nxt       = torque_r;
    pulse_nxt        = pulse_r;
    acc_nxt          = acc_r;
    elapsed_nxt      = elapsed_r;
    mag_a_nxt        = mag_a_r;
    mag_p_nxt        = mag_p_r;
    mag_s_nxt        = mag_s_r;
    neg_nxt          = neg_r;
    span_zero_nxt    = span_zero_r;
    mul_a            = '0;
    mul_b            = '0;
    div_start        = 1'b0;
    div_dvs          = SLEW_DIVISOR;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          elapsed_nxt = item.elapsed_us;
          acc_nxt     = 1'b1;
          unique case (item.operation)
            OP_TICK: begin
              if (!active) begin
                done_pending_nxt = 1'b1;
              end else if (cur_r == tgt_r) begin
                if (mode_r == MODE_MOVING) mode_nxt = MODE_HOLDING;
                done_pending_nxt = 1'b1;
              end else begin
                state_nxt = S_LIM_MUL;
              end
            end
            OP_COMMAND: begin
              if (!dest_hit) begin
                acc_nxt          = 1'b0;
                done_pending_nxt = 1'b1;
              end else if (!item.enable_flag) begin
                enabled_nxt      = 1'b0;
                mode_nxt         = MODE_DISABLED;
                pulse_nxt        = '0;
                done_pending_nxt = 1'b1;
              end else begin
                enabled_nxt = 1'b1;
                torque_nxt  = item.torque_flag;
                if (mode_r == MODE_DISABLED) mode_nxt = MODE_IDLE;
                if (item.command_kind == KIND_POSITION) begin
                  tgt_nxt = clamp_angle(item.target_value, lo16, hi16);
                  if ((mode_r == MODE_DISABLED) || (mode_r == MODE_IDLE) ||
                      (mode_r == MODE_HOLDING)) begin
                    mode_nxt = MODE_MOVING;
                  end
                end
                if ((item.command_kind == KIND_SPEED) || (item.speed_value != '0)) begin
                  speed_nxt = item.speed_value;
                end
                state_nxt = S_PM_PREP;
              end
            end
            OP_START: begin
              cur_nxt     = '0;
              tgt_nxt     = '0;
              mode_nxt    = MODE_IDLE;
              enabled_nxt = 1'b1;
              state_nxt   = S_PM_PREP;
            end
            default: begin
              acc_nxt          = 1'b0;
              done_pending_nxt = 1'b1;
            end
          endcase
        end
      end
      S_LIM_MUL: begin
        mul_a     = speed_r;
        mul_b     = elapsed_r;
        div_dvs   = SLEW_DIVISOR;
        div_start = 1'b1;
        state_nxt = S_LIM_DIV;
      end
      S_LIM_DIV: begin
        if (div_stat.done) state_nxt = S_STEP;
      end
      S_STEP: begin
        cur_nxt   = new13[11:0];
        mode_nxt  = (new13[11:0] == tgt_r) ? MODE_HOLDING : MODE_MOVING;
        state_nxt = S_PM_PREP;
      end
      S_PM_PREP: begin
        mag_a_nxt     = da14[13] ? da14_neg[12:0] : da14[12:0];
        mag_p_nxt     = dp17[16] ? dp17_neg[15:0] : dp17[15:0];
        mag_s_nxt     = span13[12] ? span13_neg[11:0] : span13[11:0];
        neg_nxt       = da14[13] ^ dp17[16] ^ span13[12];
        span_zero_nxt = (span13 == '0);
        state_nxt     = S_PM_MUL;
      end
      S_PM_MUL: begin
        if (span_zero_r) begin
          pulse_nxt        = pulse_min_r;
          done_pending_nxt = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          mul_a     = {3'b000, mag_a_r};
          mul_b     = mag_p_r;
          div_dvs   = {5'b00000, mag_s_r};
          div_start = 1'b1;
          state_nxt = S_PM_DIV;
        end
      end
      S_PM_DIV: begin
        if (div_stat.done) state_nxt = S_PM_FIN;
      end
      S_PM_FIN: begin
        pulse_nxt        = p31[15:0];
        done_pending_nxt = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A finished item moves into the output register once it is free.
    if (done_pending_r && (!out_valid_r || out_if.ready)) begin
      done_pending_nxt = 1'b0;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_fire) out_valid_nxt = 1'b0;
    if (done_pending_r && (!out_valid_r || out_if.ready)) begin
      out_nxt.accepted        = acc_r;
      out_nxt.servo_mode      = mode_r;
      out_nxt.present_angle   = cur16;
      out_nxt.goal_angle      = {{4{tgt_r[11]}}, tgt_r};
      out_nxt.pulse_width_us  = pulse_r;
      out_nxt.pulse_period_us = frame_r;
      out_nxt.torque_on       = torque_r;
      out_nxt.speed_now       = speed_r;
      out_valid_nxt           = 1'b1;
    end
  end

  sspc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      done_pending_r <= 1'b0;
      mode_r         <= MODE_DISABLED;
      enabled_r      <= 1'b0;
      cur_r          <= '0;
      tgt_r          <= '0;
      speed_r        <= RST_SPEED;
      torque_r       <= 1'b1;
      pulse_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      done_pending_r <= done_pending_nxt;
      mode_r         <= mode_nxt;
      enabled_r      <= enabled_nxt;
      cur_r          <= cur_nxt;
      tgt_r          <= tgt_nxt;
      speed_r        <= speed_nxt;
      torque_r       <= torque_nxt;
      pulse_r        <= pulse_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    elapsed_r   <= elapsed_nxt;
    mag_a_r     <= mag_a_nxt;
    mag_p_r     <= mag_p_nxt;
    mag_s_r     <= mag_s_nxt;
    neg_r       <= neg_nxt;
    span_zero_r <= span_zero_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= RST_NODE_ID;
      angle_min_r  <= RST_ANGLE_MIN;
      angle_max_r  <= RST_ANGLE_MAX;
      angle_trim_r <= RST_ANGLE_TRIM;
      pulse_min_r  <= RST_PULSE_MIN;
      pulse_max_r  <= RST_PULSE_MAX;
      frame_r      <= RST_FRAME;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_idx_t'(cfg_if.data.reg_index))
        CFG_NODE_ID:    node_id_r    <= cfg_if.data.wdata[7:0];
        CFG_ANGLE_MIN:  angle_min_r  <= cfg_if.data.wdata[11:0];
        CFG_ANGLE_MAX:  angle_max_r  <= cfg_if.data.wdata[11:0];
        CFG_ANGLE_TRIM: angle_trim_r <= cfg_if.data.wdata[11:0];
        CFG_PULSE_MIN:  pulse_min_r  <= cfg_if.data.wdata;
        CFG_PULSE_MAX:  pulse_max_r  <= cfg_if.data.wdata;
        CFG_FRAME:      frame_r      <= cfg_if.data.wdata;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while still busy");

  a_enable_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    enabled_r == (mode_r != MODE_DISABLED))
    else $error("enable flag and servo mode disagree");

  a_disabled_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DISABLED) |-> (pulse_r == '0))
    else $error("pulse width nonzero while servo disabled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("new item taken right after an accepted item");
`endif

endmodule

`default_nettype wire

FILE: rtl/sspc_div.sv
// Unsigned restoring divider that retires two quotient bits per cycle.
`default_nettype none

module sspc_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [sspc_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [sspc_pkg::DIVISOR_W-1:0]      divisor,
  output logic [sspc_pkg::DIVIDEND_W-1:0]     quotient,
  output sspc_pkg::div_stat_t                 stat
);
  import sspc_pkg::*;

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [DIVISOR_W:0]    sh1, sh2;
  logic [DIVISOR_W-1:0]  r1, r2;
  logic                  q1, q2;

  // Two dependent restoring steps; the dividend shifts out of quo_r as
  // quotient bits shift in.
  always_comb begin
    sh1 = {rem_r, quo_r[DIVIDEND_W-1]};
    q1  = (sh1 >= {1'b0, dvs_r});
    r1  = q1 ? DIVISOR_W'(sh1 - {1'b0, dvs_r}) : sh1[DIVISOR_W-1:0];
    sh2 = {r1, quo_r[DIVIDEND_W-2]};
    q2  = (sh2 >= {1'b0, dvs_r});
    r2  = q2 ? DIVISOR_W'(sh2 - {1'b0, dvs_r}) : sh2[DIVISOR_W-1:0];
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = r2;
      quo_nxt = {quo_r[DIVIDEND_W-3:0], q1, q2};
      cnt_nxt = DIV_CNT_W'(cnt_r + 1'b1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire
